>>> sv/v4a_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and saturation helper for the four-component vector alu
package v4a_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int PROD_W        = 64;
	localparam int ACC_W         = 66;
	localparam int MAG_W         = 33;
	localparam int SQ_IN_W       = 65;
	localparam int SQ_STEPS      = 33;
	localparam int SQ_LAT        = SQ_STEPS + 1;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

	typedef enum logic [3:0] {
		KIND_ADD, KIND_SUB, KIND_SCALE, KIND_DIV,
		KIND_NEG, KIND_MAGSQ, KIND_MAG, KIND_NORM,
		KIND_DOT, KIND_CROSS, KIND_REFLECT, KIND_EQ,
		KIND_ISPOINT, KIND_ISVECTOR, KIND_POINT, KIND_VECTOR
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] a_w;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] b_w;
		logic signed [31:0] factor;
	} in_t;

	typedef struct packed {
		logic signed [31:0] r_x;
		logic signed [31:0] r_y;
		logic signed [31:0] r_z;
		logic signed [31:0] r_w;
		logic signed [31:0] r_scalar;
		logic               r_flag;
		logic               r_error;
	} out_t;

	typedef struct packed {
		logic signed [31:0] val;
		logic               err;
	} sat_t;

	function automatic sat_t sat32(input logic signed [ACC_W-1:0] v);
		sat_t s;
		if (v > ACC_MAX) begin
			s.val = 32'sh7fff_ffff;
			s.err = 1'b1;
		end else if (v < ACC_MIN) begin
			s.val = 32'sh8000_0000;
			s.err = 1'b1;
		end else begin
			s.val = v[31:0];
			s.err = 1'b0;
		end
		return s;
	endfunction

endpackage

>>> sv/v4a_lane.sv
`timescale 1ns / 1ps
// one component lane: products, rounding and the reflect correction
module v4a_lane #(
	parameter int FRAC_BITS = v4a_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [31:0]                u0,
	input  logic signed [31:0]                v0,
	input  logic signed [31:0]                u1,
	input  logic signed [31:0]                v1,
	input  logic signed [31:0]                a,
	input  logic signed [31:0]                b,
	input  logic signed [31:0]                dot,
	output logic signed [v4a_pkg::PROD_W-1:0] p0,
	output v4a_pkg::sat_t                     rnd,
	output v4a_pkg::sat_t                     refl
);
	import v4a_pkg::*;

	localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] HALF_R = ACC_W'(1) << (FRAC_BITS - 2);

	logic signed [PROD_W-1:0] p0_s1, p1_s1, pr_s3;
	logic signed [31:0]       a_s1, b_s1, a_s2, b_s2, a_s3;
	sat_t                     rnd_s2;
	logic signed [ACC_W-1:0]  tr, diff;

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1  <= PROD_W'(u0) * PROD_W'(v0);
			p1_s1  <= PROD_W'(u1) * PROD_W'(v1);
			a_s1   <= a;
			b_s1   <= b;
			rnd_s2 <= sat32(((ACC_W'(p0_s1) - ACC_W'(p1_s1)) + HALF) >>> FRAC_BITS);
			a_s2   <= a_s1;
			b_s2   <= b_s1;
			pr_s3  <= PROD_W'(b_s2) * PROD_W'(dot);
			a_s3   <= a_s2;
		end
	end

	// twice b times dot, rounded, and a minus that
	always_comb begin
		tr   = (ACC_W'(pr_s3) + HALF_R) >>> (FRAC_BITS - 1);
		diff = ACC_W'(a_s3) - tr;
	end

	assign p0   = p0_s1;
	assign rnd  = rnd_s2;
	assign refl = sat32(diff);

endmodule

>>> sv/v4a_sqrt.sv
`timescale 1ns / 1ps
// pipelined integer square root, two radicand bits per stage, rounded to nearest
module v4a_sqrt (
	input  logic                              clk,
	input  logic                              en,
	input  logic [v4a_pkg::SQ_IN_W-1:0]       x,
	output logic [v4a_pkg::MAG_W-1:0]         root
);
	import v4a_pkg::*;

	localparam int XW = 2 * SQ_STEPS;
	localparam int RW = MAG_W + 4;

	logic [RW-1:0]    rem_q [SQ_STEPS];
	logic [MAG_W-1:0] rt_q  [SQ_STEPS];
	logic [XW-1:0]    x_q   [SQ_STEPS];
	logic [RW-1:0]    rem_p [SQ_STEPS];
	logic [MAG_W-1:0] rt_p  [SQ_STEPS];
	logic [XW-1:0]    x_p   [SQ_STEPS];
	logic [RW-1:0]    cur   [SQ_STEPS];
	logic [RW-1:0]    trial [SQ_STEPS];
	logic [MAG_W-1:0] root_q;

	always_comb begin
		rem_p[0] = '0;
		rt_p[0]  = '0;
		x_p[0]   = XW'(x);
		for (int k = 1; k < SQ_STEPS; k++) begin
			rem_p[k] = rem_q[k-1];
			rt_p[k]  = rt_q[k-1];
			x_p[k]   = x_q[k-1];
		end
		for (int k = 0; k < SQ_STEPS; k++) begin
			cur[k]   = {rem_p[k][RW-3:0], x_p[k][XW-1 -: 2]};
			trial[k] = RW'({rt_p[k], 2'b01});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SQ_STEPS; k++) begin
				if (cur[k] >= trial[k]) begin
					rem_q[k] <= cur[k] - trial[k];
					rt_q[k]  <= {rt_p[k][MAG_W-2:0], 1'b1};
				end else begin
					rem_q[k] <= cur[k];
					rt_q[k]  <= {rt_p[k][MAG_W-2:0], 1'b0};
				end
				x_q[k] <= {x_p[k][XW-3:0], 2'b00};
			end
			if (rem_q[SQ_STEPS-1] > RW'(rt_q[SQ_STEPS-1])) begin
				root_q <= rt_q[SQ_STEPS-1] + 1'b1;
			end else begin
				root_q <= rt_q[SQ_STEPS-1];
			end
		end
	end

	assign root = root_q;

endmodule

>>> sv/v4a_div.sv
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage, rounded half away from zero
module v4a_div #(
	parameter int NUM_W = 32 + v4a_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [NUM_W-1:0]            num,
	input  logic [v4a_pkg::MAG_W-1:0]   den,
	output logic [NUM_W:0]              quo
);
	import v4a_pkg::*;

	logic [MAG_W-1:0] rem_q [NUM_W];
	logic [MAG_W-1:0] den_q [NUM_W];
	logic [NUM_W-1:0] num_q [NUM_W];
	logic [NUM_W-1:0] quo_q [NUM_W];
	logic [MAG_W-1:0] rem_p [NUM_W];
	logic [MAG_W-1:0] den_p [NUM_W];
	logic [NUM_W-1:0] num_p [NUM_W];
	logic [NUM_W-1:0] quo_p [NUM_W];
	logic [MAG_W:0]   cur   [NUM_W];
	logic             ge    [NUM_W];
	logic [NUM_W:0]   out_q;
	logic             up;

	always_comb begin
		rem_p[0] = '0;
		den_p[0] = den;
		num_p[0] = num;
		quo_p[0] = '0;
		for (int k = 1; k < NUM_W; k++) begin
			rem_p[k] = rem_q[k-1];
			den_p[k] = den_q[k-1];
			num_p[k] = num_q[k-1];
			quo_p[k] = quo_q[k-1];
		end
		for (int k = 0; k < NUM_W; k++) begin
			cur[k] = {rem_p[k], num_p[k][NUM_W-1]};
			ge[k]  = cur[k] >= {1'b0, den_p[k]};
		end
		up = {rem_q[NUM_W-1], 1'b0} >= {1'b0, den_q[NUM_W-1]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NUM_W; k++) begin
				if (ge[k]) begin
					rem_q[k] <= MAG_W'(cur[k] - {1'b0, den_p[k]});
				end else begin
					rem_q[k] <= cur[k][MAG_W-1:0];
				end
				den_q[k] <= den_p[k];
				num_q[k] <= {num_p[k][NUM_W-2:0], 1'b0};
				quo_q[k] <= {quo_p[k][NUM_W-2:0], ge[k]};
			end
			out_q <= (NUM_W+1)'(quo_q[NUM_W-1]) + (NUM_W+1)'(up);
		end
	end

	assign quo = out_q;

endmodule

>>> sv/vector4_alu_core.sv
`timescale 1ns / 1ps
// four-component fixed-point vector alu, top level with lanes, merge and output skid
//
// channel  dir  handshake               payload
// item     in   item_valid / item_stall  v4a_pkg::in_t
// res      out  res_valid / res_stall    v4a_pkg::out_t
// tol      in   tol_we                   16-bit equality tolerance
//
// one beat per cycle in while item_stall is low, one per cycle out while res_stall is low;
// a beat passes the lanes, the bit-per-stage root and divider pipelines and then the output register
// reset clears all valid bits and loads the tolerance with 7
// the pipeline holds only while output register and skid stage both hold a beat
module vector4_alu_core #(
	parameter int FRAC_BITS = v4a_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  v4a_pkg::in_t   item,
	output logic           res_valid,
	input  logic           res_stall,
	output v4a_pkg::out_t  res,
	input  logic           tol_we,
	input  logic [15:0]    tol_wdata
);
	import v4a_pkg::*;

	localparam int NW      = 32 + FRAC_BITS;
	localparam int DIV_LAT = NW + 1;
	localparam int NA      = SQ_LAT - 1;
	localparam int T       = 2 + SQ_LAT + DIV_LAT;

	localparam logic [31:0]             ONE_W = 32'(1) << FRAC_BITS;
	localparam logic signed [32:0]      ONE_Q = {1'b0, ONE_W};
	localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) << (FRAC_BITS - 1);

	typedef struct packed {
		logic [3:0][31:0] r;
		logic [31:0]      scalar;
		logic             flag;
		logic             err;
	} res_t;

	typedef struct packed {
		kind_t            kind;
		logic [3:0][31:0] a;
		logic [31:0]      f;
		logic             divq;
		res_t             res;
	} side_t;

	function automatic logic near_eq(input logic signed [32:0] u, input logic signed [32:0] v,
			input logic [15:0] tol);
		logic signed [33:0] d;
		logic [33:0]        m;
		d = 34'(u) - 34'(v);
		m = d[33] ? 34'(-d) : 34'(d);
		return m < 34'(tol);
	endfunction

	logic [15:0]              tol_q;
	logic                     en;
	logic [T-1:0]             vld_q;
	logic signed [31:0]       a_in [4];
	logic signed [31:0]       b_in [4];
	logic signed [31:0]       u0 [4];
	logic signed [31:0]       v0 [4];
	logic signed [31:0]       u1 [4];
	logic signed [31:0]       v1 [4];
	logic signed [PROD_W-1:0] p0 [4];
	sat_t                     rnd [4];
	sat_t                     refl [4];
	sat_t                     st, qs;
	side_t                    side_in, side_s1, side_s2, side_s3, mrg3, mrg4;
	side_t                    side_a_q [NA];
	side_t                    side_b_q [DIV_LAT];
	side_t                    sa, side_e, sb;
	logic signed [ACC_W-1:0]  dsum, dsum_s2;
	sat_t                     dot_s2;
	logic [MAG_W-1:0]         mag;
	logic signed [32:0]       fe, ae;
	logic [MAG_W-1:0]         den_e;
	logic [NW-1:0]            num_e [4];
	logic [NW:0]              quo [4];
	logic                     neg;
	res_t                     fres;
	out_t                     fin, out_q, skid_q;
	logic                     out_valid_q, skid_valid_q, take;

	assign en         = !skid_valid_q;
	assign item_stall = skid_valid_q;
	assign take       = out_valid_q && !res_stall;

	assign a_in[0] = item.a_x;
	assign a_in[1] = item.a_y;
	assign a_in[2] = item.a_z;
	assign a_in[3] = item.a_w;
	assign b_in[0] = item.b_x;
	assign b_in[1] = item.b_y;
	assign b_in[2] = item.b_z;
	assign b_in[3] = item.b_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 16'd7;
		end else if (tol_we) begin
			tol_q <= tol_wdata;
		end
	end

	// lane operands
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			u0[i] = '0;
			v0[i] = '0;
			u1[i] = '0;
			v1[i] = '0;
		end
		unique case (item.kind)
			KIND_SCALE: begin
				for (int i = 0; i < 4; i++) begin
					u0[i] = a_in[i];
					v0[i] = item.factor;
				end
			end
			KIND_MAGSQ, KIND_MAG, KIND_NORM: begin
				for (int i = 0; i < 4; i++) begin
					u0[i] = a_in[i];
					v0[i] = a_in[i];
				end
			end
			KIND_DOT, KIND_REFLECT: begin
				for (int i = 0; i < 4; i++) begin
					u0[i] = a_in[i];
					v0[i] = b_in[i];
				end
			end
			KIND_CROSS: begin
				u0[0] = a_in[1]; v0[0] = b_in[2]; u1[0] = a_in[2]; v1[0] = b_in[1];
				u0[1] = a_in[2]; v0[1] = b_in[0]; u1[1] = a_in[0]; v1[1] = b_in[2];
				u0[2] = a_in[0]; v0[2] = b_in[1]; u1[2] = a_in[1]; v1[2] = b_in[0];
			end
			default: begin
			end
		endcase
	end

	// operations computed combinationally at the input
	always_comb begin
		side_in      = '0;
		side_in.kind = item.kind;
		side_in.f    = item.factor;
		for (int i = 0; i < 4; i++) begin
			side_in.a[i] = a_in[i];
		end
		st = '0;
		unique case (item.kind)
			KIND_ADD, KIND_SUB: begin
				for (int i = 0; i < 4; i++) begin
					if (item.kind == KIND_ADD) begin
						st = sat32(ACC_W'(a_in[i]) + ACC_W'(b_in[i]));
					end else begin
						st = sat32(ACC_W'(a_in[i]) - ACC_W'(b_in[i]));
					end
					side_in.res.r[i] = st.val;
					side_in.res.err  = side_in.res.err | st.err;
				end
			end
			KIND_NEG: begin
				for (int i = 0; i < 4; i++) begin
					st = sat32(-ACC_W'(a_in[i]));
					side_in.res.r[i] = st.val;
					side_in.res.err  = side_in.res.err | st.err;
				end
			end
			KIND_EQ: begin
				side_in.res.flag = near_eq(33'(a_in[0]), 33'(b_in[0]), tol_q)
					&& near_eq(33'(a_in[1]), 33'(b_in[1]), tol_q)
					&& near_eq(33'(a_in[2]), 33'(b_in[2]), tol_q)
					&& near_eq(33'(a_in[3]), 33'(b_in[3]), tol_q);
			end
			KIND_ISPOINT: begin
				side_in.res.flag = near_eq(33'(a_in[3]), ONE_Q, tol_q);
			end
			KIND_ISVECTOR: begin
				side_in.res.flag = near_eq(33'(a_in[3]), '0, tol_q);
			end
			KIND_POINT, KIND_VECTOR: begin
				side_in.res.r[0] = a_in[0];
				side_in.res.r[1] = a_in[1];
				side_in.res.r[2] = a_in[2];
				side_in.res.r[3] = (item.kind == KIND_POINT) ? ONE_W : '0;
			end
			default: begin
			end
		endcase
	end

	for (genvar i = 0; i < 4; i++) begin : g_lane
		v4a_lane #(
			.FRAC_BITS(FRAC_BITS)
		) u_lane (
			.clk  (clk),
			.en   (en),
			.u0   (u0[i]),
			.v0   (v0[i]),
			.u1   (u1[i]),
			.v1   (v1[i]),
			.a    (a_in[i]),
			.b    (b_in[i]),
			.dot  (dot_s2.val),
			.p0   (p0[i]),
			.rnd  (rnd[i]),
			.refl (refl[i])
		);
	end

	// merge of the lane products
	always_comb begin
		dsum = ACC_W'(p0[0]) + ACC_W'(p0[1]) + ACC_W'(p0[2]) + ACC_W'(p0[3]);
	end

	always_comb begin
		mrg3 = side_s2;
		unique case (side_s2.kind)
			KIND_SCALE, KIND_CROSS: begin
				for (int i = 0; i < 4; i++) begin
					mrg3.res.r[i] = rnd[i].val;
					mrg3.res.err  = mrg3.res.err | rnd[i].err;
				end
			end
			KIND_DOT, KIND_MAGSQ: begin
				mrg3.res.scalar = dot_s2.val;
				mrg3.res.err    = dot_s2.err;
			end
			KIND_REFLECT: begin
				mrg3.res.err = dot_s2.err;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		mrg4 = side_s3;
		if (side_s3.kind == KIND_REFLECT) begin
			for (int i = 0; i < 4; i++) begin
				mrg4.res.r[i] = refl[i].val;
				mrg4.res.err  = mrg4.res.err | refl[i].err;
			end
		end
	end

	v4a_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.x    (dsum_s2[SQ_IN_W-1:0]),
		.root (mag)
	);

	// divider entry: magnitude known, choose divisor and numerators, finish mag and flag a zero divisor
	always_comb begin
		sa     = side_a_q[NA-1];
		side_e = sa;
		fe     = 33'($signed(sa.f));
		den_e  = (sa.kind == KIND_NORM) ? mag : MAG_W'(fe[32] ? -fe : fe);
		for (int i = 0; i < 4; i++) begin
			ae        = 33'($signed(sa.a[i]));
			num_e[i]  = {32'(ae[32] ? -ae : ae), {FRAC_BITS{1'b0}}};
		end
		unique case (sa.kind)
			KIND_MAG: begin
				if (mag[MAG_W-1] || mag[MAG_W-2]) begin
					side_e.res.scalar = 32'h7fff_ffff;
					side_e.res.err    = 1'b1;
				end else begin
					side_e.res.scalar = mag[31:0];
				end
			end
			KIND_DIV, KIND_NORM: begin
				if (den_e == '0) begin
					side_e.res.err = 1'b1;
				end else begin
					side_e.divq = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	for (genvar i = 0; i < 4; i++) begin : g_div
		v4a_div #(
			.NUM_W(NW)
		) u_div (
			.clk (clk),
			.en  (en),
			.num (num_e[i]),
			.den (den_e),
			.quo (quo[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1     <= side_in;
			side_s2     <= side_s1;
			dsum_s2     <= dsum;
			dot_s2      <= sat32((dsum + HALF) >>> FRAC_BITS);
			side_s3     <= mrg3;
			side_a_q[0] <= mrg4;
			for (int k = 1; k < NA; k++) begin
				side_a_q[k] <= side_a_q[k-1];
			end
			side_b_q[0] <= side_e;
			for (int k = 1; k < DIV_LAT; k++) begin
				side_b_q[k] <= side_b_q[k-1];
			end
		end
	end

	// final sign and saturation of the quotients
	always_comb begin
		sb   = side_b_q[DIV_LAT-1];
		fres = sb.res;
		neg  = 1'b0;
		qs   = '0;
		if (sb.divq) begin
			for (int i = 0; i < 4; i++) begin
				neg = sb.a[i][31] ^ ((sb.kind == KIND_DIV) && sb.f[31]);
				if (neg) begin
					qs = sat32(-$signed(ACC_W'(quo[i])));
				end else begin
					qs = sat32($signed(ACC_W'(quo[i])));
				end
				fres.r[i] = qs.val;
				fres.err  = fres.err | qs.err;
			end
		end
		fin.r_x      = fres.r[0];
		fin.r_y      = fres.r[1];
		fin.r_z      = fres.r[2];
		fin.r_w      = fres.r[3];
		fin.r_scalar = fres.scalar;
		fin.r_flag   = fres.flag;
		fin.r_error  = fres.err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q        <= '0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (en) begin
				vld_q <= {vld_q[T-2:0], item_valid};
			end
			if (skid_valid_q) begin
				if (take) begin
					skid_valid_q <= 1'b0;
				end
			end else if (vld_q[T-1]) begin
				out_valid_q <= 1'b1;
				if (out_valid_q && !take) begin
					skid_valid_q <= 1'b1;
				end
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (vld_q[T-1]) begin
			if (!out_valid_q || take) begin
				out_q <= fin;
			end else begin
				skid_q <= fin;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid beat held without an output beat");

	a_hold_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved while the skid stage was full");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !skid_valid_q && !vld_q[T-1]) |=> !out_valid_q)
		else $error("output beat repeated after it was taken");

endmodule
